/* sv/tcce_pkg.sv */
// tcce_pkg: shared types, codes and constants of the text console cursor engine
// used by every module of the block but tcce_ram; depends on nothing
`default_nettype none

package tcce_pkg;

    // geometry defaults
    localparam int COLUMNS_DEF     = 80;
    localparam int ROWS_DEF        = 25;
    localparam int TAB_STOP_DEF    = 4;
    localparam int QUEUE_DEPTH_DEF = 2;

    // field widths
    localparam int OP_W     = 2;
    localparam int GLYPH_W  = 8;
    localparam int ATTR_W   = 8;
    localparam int COLREQ_W = 8;
    localparam int POS_W    = 11;
    localparam int CELL_W   = 16;

    // attribute after reset and control characters
    localparam logic [ATTR_W-1:0]  ATTR_RESET   = 8'h0F;
    localparam logic [GLYPH_W-1:0] CH_BACKSPACE = 8'd8;
    localparam logic [GLYPH_W-1:0] CH_TAB       = 8'd9;
    localparam logic [GLYPH_W-1:0] CH_NEWLINE   = 8'd10;
    localparam logic [GLYPH_W-1:0] CH_RETURN    = 8'd13;
    localparam logic [GLYPH_W-1:0] CH_SPACE     = 8'h20;

    // reciprocal scaling used for the column modulo tab stop
    localparam int TAB_SHIFT = 16;

    typedef enum logic [OP_W-1:0] {
        OP_PUT        = 2'd0,
        OP_CLEAR      = 2'd1,
        OP_SET_COLUMN = 2'd2,
        OP_READ       = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        CMD_GLYPH,
        CMD_NEWLINE,
        CMD_RETURN,
        CMD_BACKSPACE,
        CMD_TAB,
        CMD_CLEAR,
        CMD_SET_COLUMN,
        CMD_READ
    } cmd_kind_t;

    typedef enum logic [3:0] {
        BE_INIT,
        BE_IDLE,
        BE_EXEC,
        BE_PUT,
        BE_ERASE,
        BE_TAB_DIV,
        BE_TAB_REM,
        BE_SCROLL,
        BE_BLANK_ROW,
        BE_CLEAR,
        BE_READ_WAIT,
        BE_DONE
    } be_state_t;

    typedef struct packed {
        logic [OP_W-1:0]     operation;
        logic [GLYPH_W-1:0]  char_code;
        logic [COLREQ_W-1:0] column_request;
        logic [POS_W-1:0]    cell_index;
    } req_t;

    typedef struct packed {
        logic [POS_W-1:0]  cursor_position;
        logic [CELL_W-1:0] read_cell;
        logic              scrolled;
    } rsp_t;

    // classified command handed from the front to the back
    typedef struct packed {
        cmd_kind_t           kind;
        logic [GLYPH_W-1:0]  glyph;
        logic [COLREQ_W-1:0] column;
        logic [POS_W-1:0]    index;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    typedef struct packed {
        logic init_busy;
        logic idle;
    } be_status_t;

endpackage

`default_nettype wire

/* sv/tcce_ram.sv */
// tcce_ram: generic single write port, single read port ram with registered read
// no dependencies
`default_nettype none

module tcce_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

/* sv/tcce_front.sv */
// tcce_front: request handshake and classification of requests into commands
// depends on tcce_pkg
`default_nettype none

module tcce_front
    import tcce_pkg::*;
#(
    parameter int COLUMNS = COLUMNS_DEF
) (
    input  wire logic       req_valid,
    input  wire req_t       req,
    output logic            req_stall,
    input  wire q_status_t  q_stat,
    input  wire be_status_t be_stat,
    output logic            push,
    output cmd_t            push_cmd
);

    localparam logic [COLREQ_W-1:0] COL_LAST = COLREQ_W'(COLUMNS - 1);

    // no requests while the queue is full or the screen is still being blanked
    assign req_stall = q_stat.full || be_stat.init_busy;
    assign push      = req_valid && !req_stall;

    always_comb
    begin
        push_cmd.glyph  = req.char_code;
        push_cmd.index  = req.cell_index;
        push_cmd.column = (req.column_request > COL_LAST) ? COL_LAST : req.column_request;
        case (op_t'(req.operation))
            OP_PUT:
            begin
                case (req.char_code)
                    CH_NEWLINE:   push_cmd.kind = CMD_NEWLINE;
                    CH_RETURN:    push_cmd.kind = CMD_RETURN;
                    CH_BACKSPACE: push_cmd.kind = CMD_BACKSPACE;
                    CH_TAB:       push_cmd.kind = CMD_TAB;
                    default:      push_cmd.kind = CMD_GLYPH;
                endcase
            end
            OP_CLEAR:      push_cmd.kind = CMD_CLEAR;
            OP_SET_COLUMN: push_cmd.kind = CMD_SET_COLUMN;
            OP_READ:       push_cmd.kind = CMD_READ;
            default:       push_cmd.kind = CMD_READ;
        endcase
    end

endmodule

`default_nettype wire

/* sv/tcce_queue.sv */
// tcce_queue: short command queue between the front and the back
// depends on tcce_pkg
`default_nettype none

module tcce_queue
    import tcce_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  wire cmd_t push_cmd,
    input  wire logic pop,
    output cmd_t      pop_cmd,
    output q_status_t q_stat
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    cmd_t             entries_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    assign pop_cmd      = entries_reg[rd_ptr_reg];
    assign q_stat.full  = (count_reg == CNT_W'(DEPTH));
    assign q_stat.empty = (count_reg == '0);

endmodule

`default_nettype wire

/* sv/tcce_back.sv */
// tcce_back: command sequencer that owns the cursor, the screen ram and the result register
// depends on tcce_pkg and tcce_ram
`default_nettype none

module tcce_back
    import tcce_pkg::*;
#(
    parameter int COLUMNS  = COLUMNS_DEF,
    parameter int ROWS     = ROWS_DEF,
    parameter int TAB_STOP = TAB_STOP_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic [ATTR_W-1:0] attr,
    input  wire q_status_t         q_stat,
    input  wire cmd_t              pop_cmd,
    output logic                   pop,
    output be_status_t             be_stat,
    output logic                   rsp_valid,
    input  wire logic              rsp_stall,
    output rsp_t                   rsp
);

    localparam int CELL_COUNT = COLUMNS * ROWS;
    localparam int AW         = $clog2(CELL_COUNT);
    localparam int SW         = $clog2(CELL_COUNT + 1);
    localparam int RW         = $clog2(ROWS);
    localparam int CW         = $clog2(COLUMNS);
    localparam int PW         = $clog2(TAB_STOP + 1);
    localparam int WIDE_W     = POS_W + AW;
    localparam int RECIP_W    = TAB_SHIFT + 1;
    localparam int PROD_W     = COLREQ_W + RECIP_W;
    localparam logic [RECIP_W-1:0] TAB_RECIP =
        RECIP_W'(((2 ** TAB_SHIFT) + TAB_STOP - 1) / TAB_STOP);
    localparam logic [SW-1:0] COPY_LAST  = SW'(CELL_COUNT - COLUMNS);
    localparam logic [SW-1:0] CELL_LAST  = SW'(CELL_COUNT - 1);

    be_state_t            state_reg, state_next;
    logic [RW-1:0]        row_reg, row_next;
    logic [CW-1:0]        col_reg, col_next;
    logic [SW-1:0]        sweep_reg, sweep_next;
    logic                 rsp_valid_reg, rsp_valid_next;
    cmd_t                 cmd_reg, cmd_next;
    logic [PW-1:0]        phase_reg, phase_next;
    logic [COLREQ_W-1:0]  quot_reg, quot_next;
    logic [CELL_W-1:0]    cell_reg, cell_next;
    logic                 scrolled_reg, scrolled_next;
    rsp_t                 rsp_reg, rsp_next;

    logic                 ram_we;
    logic [AW-1:0]        ram_waddr;
    logic [CELL_W-1:0]    ram_wdata;
    logic [AW-1:0]        ram_raddr;
    logic [CELL_W-1:0]    ram_rdata;

    logic [AW-1:0]        cur_pos;
    logic [WIDE_W-1:0]    pos_wide;
    logic [WIDE_W-1:0]    idx_wide;
    logic                 idx_in_range;
    logic                 at_row_end;
    logic                 row_last;
    logic [PW-1:0]        phase_inc;
    logic [PROD_W-1:0]    tab_prod;
    logic [COLREQ_W-1:0]  tab_rem;
    logic [ATTR_W-1:0]    attr_sel;
    logic [CELL_W-1:0]    blank_cell;
    logic [GLYPH_W-1:0]   put_glyph;

    tcce_ram #(
        .WIDTH (CELL_W),
        .DEPTH (CELL_COUNT)
    ) u_screen (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // cursor address and helpers
    always_comb
    begin
        cur_pos      = (AW'(row_reg) * AW'(COLUMNS)) + AW'(col_reg);
        pos_wide     = WIDE_W'(cur_pos);
        idx_wide     = WIDE_W'(cmd_reg.index);
        idx_in_range = idx_wide < WIDE_W'(CELL_COUNT);
        at_row_end   = (col_reg == CW'(COLUMNS - 1));
        row_last     = (row_reg == RW'(ROWS - 1));
        phase_inc    = (phase_reg == PW'(TAB_STOP - 1)) ? '0 : phase_reg + PW'(1);
        tab_prod     = PROD_W'(col_reg) * PROD_W'(TAB_RECIP);
        tab_rem      = COLREQ_W'(col_reg) - COLREQ_W'(quot_reg * COLREQ_W'(TAB_STOP));
        attr_sel     = (state_reg == BE_INIT) ? ATTR_RESET : attr;
        blank_cell   = {attr_sel, CH_SPACE};
        put_glyph    = (cmd_reg.kind == CMD_TAB) ? CH_SPACE : cmd_reg.glyph;
    end

    always_comb
    begin
        state_next     = state_reg;
        row_next       = row_reg;
        col_next       = col_reg;
        sweep_next     = sweep_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        cmd_next       = cmd_reg;
        phase_next     = phase_reg;
        quot_next      = quot_reg;
        cell_next      = cell_reg;
        scrolled_next  = scrolled_reg;
        rsp_next       = rsp_reg;
        pop            = 1'b0;
        ram_we         = 1'b0;
        ram_waddr      = AW'(sweep_reg);
        ram_wdata      = blank_cell;
        ram_raddr      = idx_wide[AW-1:0];

        case (state_reg)
            BE_INIT, BE_CLEAR:
            begin
                ram_we = 1'b1;
                if (sweep_reg == CELL_LAST)
                begin
                    sweep_next = '0;
                    row_next   = '0;
                    col_next   = '0;
                    state_next = (state_reg == BE_INIT) ? BE_IDLE : BE_DONE;
                end
                else
                begin
                    sweep_next = sweep_reg + SW'(1);
                end
            end
            BE_IDLE:
            begin
                if (!q_stat.empty)
                begin
                    pop           = 1'b1;
                    cmd_next      = pop_cmd;
                    cell_next     = '0;
                    scrolled_next = 1'b0;
                    state_next    = BE_EXEC;
                end
            end
            BE_EXEC:
            begin
                case (cmd_reg.kind)
                    CMD_GLYPH:   state_next = BE_PUT;
                    CMD_TAB:     state_next = BE_TAB_DIV;
                    CMD_NEWLINE:
                    begin
                        col_next = '0;
                        if (row_last)
                        begin
                            sweep_next = '0;
                            state_next = BE_SCROLL;
                        end
                        else
                        begin
                            row_next   = row_reg + RW'(1);
                            state_next = BE_DONE;
                        end
                    end
                    CMD_RETURN:
                    begin
                        col_next   = '0;
                        state_next = BE_DONE;
                    end
                    CMD_BACKSPACE:
                    begin
                        if (col_reg != '0)
                        begin
                            col_next = col_reg - CW'(1);
                        end
                        state_next = BE_ERASE;
                    end
                    CMD_CLEAR:
                    begin
                        sweep_next = '0;
                        state_next = BE_CLEAR;
                    end
                    CMD_SET_COLUMN:
                    begin
                        col_next   = CW'(cmd_reg.column);
                        state_next = BE_DONE;
                    end
                    CMD_READ:    state_next = BE_READ_WAIT;
                    default:     state_next = BE_DONE;
                endcase
            end
            BE_TAB_DIV:
            begin
                quot_next  = tab_prod[TAB_SHIFT +: COLREQ_W];
                state_next = BE_TAB_REM;
            end
            BE_TAB_REM:
            begin
                phase_next = PW'(tab_rem);
                state_next = BE_PUT;
            end
            BE_PUT:
            begin
                ram_we    = 1'b1;
                ram_waddr = cur_pos;
                ram_wdata = {attr, put_glyph};
                if (at_row_end)
                begin
                    // wrap ends a tab since column zero is a tab stop
                    col_next   = '0;
                    phase_next = '0;
                    if (row_last)
                    begin
                        sweep_next = '0;
                        state_next = BE_SCROLL;
                    end
                    else
                    begin
                        row_next   = row_reg + RW'(1);
                        state_next = BE_DONE;
                    end
                end
                else
                begin
                    col_next   = col_reg + CW'(1);
                    phase_next = phase_inc;
                    if (!(cmd_reg.kind == CMD_TAB && phase_inc != '0))
                    begin
                        state_next = BE_DONE;
                    end
                end
            end
            BE_ERASE:
            begin
                ram_we     = 1'b1;
                ram_waddr  = cur_pos;
                state_next = BE_DONE;
            end
            BE_SCROLL:
            begin
                // read one row ahead, write the word read in the previous cycle
                scrolled_next = 1'b1;
                ram_raddr     = AW'(sweep_reg) + AW'(COLUMNS);
                ram_we        = (sweep_reg != '0);
                ram_waddr     = AW'(sweep_reg - SW'(1));
                ram_wdata     = ram_rdata;
                if (sweep_reg == COPY_LAST)
                begin
                    state_next = BE_BLANK_ROW;
                end
                else
                begin
                    sweep_next = sweep_reg + SW'(1);
                end
            end
            BE_BLANK_ROW:
            begin
                ram_we = 1'b1;
                if (sweep_reg == CELL_LAST)
                begin
                    sweep_next = '0;
                    state_next = BE_DONE;
                end
                else
                begin
                    sweep_next = sweep_reg + SW'(1);
                end
            end
            BE_READ_WAIT:
            begin
                cell_next  = idx_in_range ? ram_rdata : '0;
                state_next = BE_DONE;
            end
            BE_DONE:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_valid_next           = 1'b1;
                    rsp_next.cursor_position = pos_wide[POS_W-1:0];
                    rsp_next.read_cell       = cell_reg;
                    rsp_next.scrolled        = scrolled_reg;
                    state_next               = BE_IDLE;
                end
            end
            default:
            begin
                state_next = BE_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BE_INIT;
            row_reg       <= '0;
            col_reg       <= '0;
            sweep_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            row_reg       <= row_next;
            col_reg       <= col_next;
            sweep_reg     <= sweep_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        phase_reg    <= phase_next;
        quot_reg     <= quot_next;
        cell_reg     <= cell_next;
        scrolled_reg <= scrolled_next;
        rsp_reg      <= rsp_next;
    end

    assign be_stat.init_busy = (state_reg == BE_INIT);
    assign be_stat.idle      = (state_reg == BE_IDLE);
    assign rsp_valid         = rsp_valid_reg;
    assign rsp               = rsp_reg;

endmodule

`default_nettype wire

/* sv/text_console_cursor_engine_top.sv */
// text_console_cursor_engine_top: top level of the text console cursor engine
// depends on tcce_pkg, tcce_front, tcce_queue, tcce_back (and tcce_ram below it)
//
// usage
//   request channel (req_valid, req_stall, req): one transaction per operation, accepted
//   when req_valid is high and req_stall low; put character, clear screen, set column,
//   read cell. response channel (rsp_valid, rsp_stall, rsp): exactly one transaction per
//   request, in order, carrying the cursor position, the cell read and the scroll flag.
//   configuration channel (cfg_valid, cfg_ready, cfg_data): writes the attribute byte;
//   cfg_ready is always high, write only while the engine is idle.
// sequencing
//   a tab first computes the column modulo the tab stop, then writes spaces up to the next
//   tab stop; clear blanks every cell; any scroll copies the screen up a row with the
//   one-cell-per-cycle copy through the single screen ram write port, then blanks the last row.
//   a response is loaded into the output register when the sequencer finishes the operation.
// reset
//   rst_n is asynchronous; afterwards the screen ram is blanked to 0x0F20, one cell per
//   cycle, with req_stall held high; configuration is taken.
// stalls
//   a response waits in the output register while rsp_stall is high; the two-entry
//   command queue keeps taking requests until it fills, then req_stall rises.
`default_nettype none

module text_console_cursor_engine_top
    import tcce_pkg::*;
#(
    parameter int COLUMNS     = COLUMNS_DEF,
    parameter int ROWS        = ROWS_DEF,
    parameter int TAB_STOP    = TAB_STOP_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              req_valid,
    output logic                   req_stall,
    input  wire req_t              req,
    output logic                   rsp_valid,
    input  wire logic              rsp_stall,
    output rsp_t                   rsp,
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic [ATTR_W-1:0] cfg_data
);

    logic [ATTR_W-1:0] attr_reg, attr_next;
    q_status_t         q_stat;
    be_status_t        be_stat;
    logic              push;
    cmd_t              push_cmd;
    logic              pop;
    cmd_t              pop_cmd;

    // attribute register, written by a configuration transaction
    assign cfg_ready = 1'b1;
    assign attr_next = (cfg_valid && cfg_ready) ? cfg_data : attr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            attr_reg <= ATTR_RESET;
        end
        else
        begin
            attr_reg <= attr_next;
        end
    end

    // front: handshake and decode of control characters
    tcce_front #(
        .COLUMNS (COLUMNS)
    ) u_front (
        .req_valid (req_valid),
        .req       (req),
        .req_stall (req_stall),
        .q_stat    (q_stat),
        .be_stat   (be_stat),
        .push      (push),
        .push_cmd  (push_cmd)
    );

    // queue decouples request acceptance from long scroll and clear sweeps
    tcce_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .pop_cmd  (pop_cmd),
        .q_stat   (q_stat)
    );

    // back: cursor, screen memory sweeps and response register
    tcce_back #(
        .COLUMNS  (COLUMNS),
        .ROWS     (ROWS),
        .TAB_STOP (TAB_STOP)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .attr      (attr_reg),
        .q_stat    (q_stat),
        .pop_cmd   (pop_cmd),
        .pop       (pop),
        .be_stat   (be_stat),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

`ifndef NO_ASSERTIONS
    // a scrolling operation is a put, which never returns cell data
    a_scroll_no_cell: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.scrolled |-> rsp.read_cell == '0)
        else $error("scrolled response carries cell data");

    // no request is taken while the screen is blanked after reset
    a_init_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        be_stat.init_busy |-> req_stall)
        else $error("request accepted during reset blanking");

    // the reset blanking pass runs once and never restarts
    a_init_once: assert property (@(posedge clk) disable iff (!rst_n)
        !$past(be_stat.init_busy) |-> !be_stat.init_busy)
        else $error("reset blanking restarted");
`endif

endmodule

`default_nettype wire
